// ===== src/apusv_pkg.sv =====
package apusv_pkg;

    localparam int TRIGGER_COUNT_BITS = 8;
    localparam int CLK_BITS = 22;
    localparam int NUM_BITS = CLK_BITS + 24;
    localparam int DEN_BITS = 40;
    localparam int REM_BITS = DEN_BITS + 1;
    localparam int QUO_BITS = NUM_BITS + 1;
    localparam int STEP_BITS = 6;

    localparam logic [0:0] CFG_CPU_CLOCK = 1'b0;
    localparam logic [0:0] CFG_SYNTH_CLOCK = 1'b1;
    localparam logic [CLK_BITS-1:0] CPU_CLOCK_RESET = 22'd1789773;
    localparam logic [CLK_BITS-1:0] SYNTH_CLOCK_RESET = 22'd985248;

    localparam logic [1:0] OWNER_NONE = 2'd0;
    localparam logic [1:0] OWNER_TRIANGLE = 2'd1;
    localparam logic [1:0] OWNER_NOISE = 2'd2;

    localparam logic [7:0] CTRL_NOISE = 8'h81;
    localparam logic [7:0] CTRL_TRIANGLE = 8'h11;
    localparam logic [7:0] CTRL_OFF = 8'h10;
    localparam logic [7:0] CTRL_PULSE = 8'h40;
    localparam logic [7:0] VOLUME_FULL = 8'hf0;
    localparam logic [7:0] MASTER_VOLUME = 8'h0f;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_STORE,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic [1:0] voice;
        logic       step;
        logic       store;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic silence;
    } status_t;

    function automatic logic [15:0] width_of(input logic [1:0] duty);
        logic [15:0] w;
        begin
            unique case (duty)
                2'd0: w = 16'h0200;
                2'd1: w = 16'h0400;
                2'd2: w = 16'h0800;
                default: w = 16'h0c00;
            endcase
            return w;
        end
    endfunction

    function automatic logic [11:0] noise_length(input logic [3:0] sel);
        logic [11:0] p;
        begin
            unique case (sel)
                4'd0: p = 12'd4;
                4'd1: p = 12'd8;
                4'd2: p = 12'd16;
                4'd3: p = 12'd32;
                4'd4: p = 12'd64;
                4'd5: p = 12'd96;
                4'd6: p = 12'd128;
                4'd7: p = 12'd160;
                4'd8: p = 12'd202;
                4'd9: p = 12'd254;
                4'd10: p = 12'd380;
                4'd11: p = 12'd508;
                4'd12: p = 12'd762;
                4'd13: p = 12'd1016;
                4'd14: p = 12'd2034;
                default: p = 12'd4068;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== src/apusv_ctrl.sv =====
module apusv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  apusv_pkg::status_t  status,
    output apusv_pkg::cmd_t     cmd
);

    apusv_pkg::state_t state_reg, state_next;
    logic [1:0] voice_reg, voice_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apusv_pkg::ST_IDLE;
            voice_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            voice_reg <= voice_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        voice_next = voice_reg;
        cmd = '0;
        cmd.voice = voice_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            apusv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    voice_next = 2'd0;
                    state_next = apusv_pkg::ST_LOAD;
                end
            end
            apusv_pkg::ST_LOAD:
            begin
                if (status.silence)
                begin
                    cmd.finish = 1'b1;
                    state_next = apusv_pkg::ST_OUTPUT;
                end
                else
                begin
                    cmd.load = 1'b1;
                    state_next = apusv_pkg::ST_DIVIDE;
                end
            end
            apusv_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.div_done)
                    state_next = apusv_pkg::ST_STORE;
            end
            apusv_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
                if (voice_reg == 2'd2)
                    state_next = apusv_pkg::ST_FINISH;
                else
                begin
                    voice_next = voice_reg + 2'd1;
                    state_next = apusv_pkg::ST_LOAD;
                end
            end
            apusv_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = apusv_pkg::ST_OUTPUT;
            end
            apusv_pkg::ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = apusv_pkg::ST_IDLE;
            end
            default:
                state_next = apusv_pkg::ST_IDLE;
        endcase
    end

    a_single_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output both open");
    a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> $past(state_reg == apusv_pkg::ST_DIVIDE)) else $error("store without divide");
    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        voice_reg != 2'd3) else $error("voice out of range");

endmodule

// ===== src/apusv_dp.sv =====
module apusv_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  apusv_pkg::cmd_t     cmd,
    output apusv_pkg::status_t  status,
    input  logic                cfg_valid,
    input  logic [0:0]          cfg_index,
    input  logic [21:0]         cfg_data,
    input  logic                mode,
    input  logic [7:0]          pulse1_control,
    input  logic [10:0]         pulse1_timer,
    input  logic [7:0]          pulse2_control,
    input  logic [10:0]         pulse2_timer,
    input  logic [10:0]         triangle_period,
    input  logic [7:0]          noise_control,
    input  logic [7:0]          noise_select,
    input  logic [3:0]          channel_enable,
    input  logic [3:0]          length_nonzero,
    input  logic [31:0]         trigger_counts,
    output logic                changed,
    output logic [2:0]          retrigger_mask,
    output logic [55:0]         voice1_regs,
    output logic [55:0]         voice2_regs,
    output logic [55:0]         voice3_regs,
    output logic [31:0]         global_regs
);

    localparam int TB = apusv_pkg::TRIGGER_COUNT_BITS;

    logic [21:0] cpu_reg, synth_reg;
    logic        mode_reg;
    logic [7:0]  p1c_reg, p2c_reg, nc_reg, np_reg;
    logic [10:0] p1t_reg, p2t_reg, tt_reg;
    logic [3:0]  en_reg, len_reg;
    logic [31:0] trig_reg;

    logic [55:0] prior_v1_reg, prior_v2_reg, prior_v3_reg;
    logic        prior_master_reg;
    logic [1:0]  prior_owner_reg;
    logic [TB-1:0] seen_reg [4];

    logic [15:0] w1_reg, w2_reg, w3_reg;
    logic        changed_reg;
    logic [2:0]  retrig_reg;
    logic [55:0] v1_reg, v2_reg, v3_reg;
    logic [31:0] g_reg;

    logic [apusv_pkg::REM_BITS-1:0] rem_reg;
    logic [apusv_pkg::QUO_BITS-1:0] num_reg;
    logic [apusv_pkg::DEN_BITS-1:0] den_reg;
    logic [apusv_pkg::STEP_BITS-1:0] cnt_reg;
    logic        zero_reg;

    // Noise takes voice 3 ahead of the triangle.
    logic p1_on, p2_on, tri_on, noise_on;
    logic [1:0] owner;
    assign p1_on = en_reg[0] && len_reg[0] && (p1t_reg >= 11'd8) && (p1c_reg[3:0] != 4'd0);
    assign p2_on = en_reg[1] && len_reg[1] && (p2t_reg >= 11'd8) && (p2c_reg[3:0] != 4'd0);
    assign tri_on = en_reg[2] && len_reg[2] && (tt_reg >= 11'd2);
    assign noise_on = en_reg[3] && len_reg[3] && (nc_reg[3:0] != 4'd0);
    assign owner = noise_on ? apusv_pkg::OWNER_NOISE :
                   (tri_on ? apusv_pkg::OWNER_TRIANGLE : apusv_pkg::OWNER_NONE);

    // Divisor = factor * synth clock, factor from the voice.
    logic [17:0] factor;
    logic [apusv_pkg::DEN_BITS-1:0] den_load;
    always_comb
    begin
        unique case (cmd.voice)
            2'd0: factor = {2'd0, {1'b0, p1t_reg} + 12'd1, 4'd0};
            2'd1: factor = {2'd0, {1'b0, p2t_reg} + 12'd1, 4'd0};
            default:
                if (owner == apusv_pkg::OWNER_NOISE)
                    factor = {5'd0, apusv_pkg::noise_length(np_reg[3:0]), 1'b0};
                else
                    factor = {1'b0, {1'b0, tt_reg} + 12'd1, 5'd0};
        endcase
        den_load = apusv_pkg::DEN_BITS'({22'd0, factor} * {18'd0, synth_reg});
    end

    // Restoring divider on num + den/2, one quotient bit per cycle.
    logic [apusv_pkg::REM_BITS-1:0] rem_shift;
    logic [apusv_pkg::REM_BITS-1:0] rem_sub;
    logic fits;
    assign rem_shift = {rem_reg[apusv_pkg::REM_BITS-2:0], num_reg[apusv_pkg::QUO_BITS-1]};
    assign fits = rem_shift >= {1'b0, den_reg};
    assign rem_sub = rem_shift - {1'b0, den_reg};
    assign status.div_done = (cnt_reg == apusv_pkg::STEP_BITS'(apusv_pkg::QUO_BITS - 1));
    assign status.silence = mode_reg;

    logic [15:0] wq;
    assign wq = zero_reg ? 16'd0 :
        ((num_reg[apusv_pkg::QUO_BITS-1:16] != '0) ? 16'hffff : num_reg[15:0]);

    logic [TB-1:0] tv [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            tv[i] = TB'(trig_reg >> (i * TB));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg <= apusv_pkg::CPU_CLOCK_RESET;
            synth_reg <= apusv_pkg::SYNTH_CLOCK_RESET;
            prior_v1_reg <= '0;
            prior_v2_reg <= '0;
            prior_v3_reg <= '0;
            prior_master_reg <= 1'b0;
            prior_owner_reg <= apusv_pkg::OWNER_NONE;
            for (int i = 0; i < 4; i++)
                seen_reg[i] <= '0;
            cnt_reg <= '0;
            changed_reg <= 1'b0;
            retrig_reg <= 3'd0;
            v1_reg <= '0;
            v2_reg <= '0;
            v3_reg <= '0;
            g_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    apusv_pkg::CFG_CPU_CLOCK: cpu_reg <= cfg_data;
                    default: synth_reg <= cfg_data;
                endcase
            end
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.step)
                cnt_reg <= cnt_reg + apusv_pkg::STEP_BITS'(1);
            if (cmd.finish)
            begin
                if (mode_reg)
                begin
                    prior_v1_reg <= '0;
                    prior_v2_reg <= '0;
                    prior_v3_reg <= '0;
                    prior_master_reg <= 1'b0;
                    prior_owner_reg <= apusv_pkg::OWNER_NONE;
                    changed_reg <= 1'b0;
                    retrig_reg <= 3'd0;
                    v1_reg <= '0;
                    v2_reg <= '0;
                    v3_reg <= '0;
                    g_reg <= '0;
                end
                else
                begin : render
                    logic [55:0] n1, n2, n3;
                    logic [2:0] rt;
                    n1 = {8'(p1c_reg[3:0]) << 4, 8'd0, apusv_pkg::CTRL_PULSE | {7'd0, p1_on},
                          apusv_pkg::width_of(p1c_reg[7:6]), w1_reg};
                    n2 = {8'(p2c_reg[3:0]) << 4, 8'd0, apusv_pkg::CTRL_PULSE | {7'd0, p2_on},
                          apusv_pkg::width_of(p2c_reg[7:6]), w2_reg};
                    rt = 3'd0;
                    rt[0] = p1_on && ((tv[0] != seen_reg[0]) || !prior_v1_reg[32]);
                    rt[1] = p2_on && ((tv[1] != seen_reg[1]) || !prior_v2_reg[32]);
                    unique case (owner)
                        apusv_pkg::OWNER_NOISE:
                        begin
                            n3 = {8'(nc_reg[3:0]) << 4, 8'd0, apusv_pkg::CTRL_NOISE,
                                  16'd0, w3_reg};
                            rt[2] = (tv[3] != seen_reg[3]) ||
                                    (prior_owner_reg != apusv_pkg::OWNER_NOISE) ||
                                    !prior_v3_reg[32];
                        end
                        apusv_pkg::OWNER_TRIANGLE:
                        begin
                            n3 = {apusv_pkg::VOLUME_FULL, 8'd0, apusv_pkg::CTRL_TRIANGLE,
                                  16'd0, w3_reg};
                            rt[2] = (tv[2] != seen_reg[2]) ||
                                    (prior_owner_reg != apusv_pkg::OWNER_TRIANGLE) ||
                                    !prior_v3_reg[32];
                        end
                        default:
                            n3 = {16'd0, apusv_pkg::CTRL_OFF, 32'd0};
                    endcase
                    // The global bytes only differ from the previous image after reset
                    // or silence, when the master volume byte was still clear.
                    changed_reg <= (rt != 3'd0) || (n1 != prior_v1_reg) ||
                                   (n2 != prior_v2_reg) || (n3 != prior_v3_reg) ||
                                   !prior_master_reg;
                    retrig_reg <= rt;
                    v1_reg <= n1;
                    v2_reg <= n2;
                    v3_reg <= n3;
                    g_reg <= {apusv_pkg::MASTER_VOLUME, 24'd0};
                    prior_v1_reg <= n1;
                    prior_v2_reg <= n2;
                    prior_v3_reg <= n3;
                    prior_master_reg <= 1'b1;
                    prior_owner_reg <= owner;
                    for (int i = 0; i < 4; i++)
                        seen_reg[i] <= tv[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            p1c_reg <= pulse1_control;
            p1t_reg <= pulse1_timer;
            p2c_reg <= pulse2_control;
            p2t_reg <= pulse2_timer;
            tt_reg <= triangle_period;
            nc_reg <= noise_control;
            np_reg <= noise_select;
            en_reg <= channel_enable;
            len_reg <= length_nonzero;
            trig_reg <= trigger_counts;
        end
        if (cmd.load)
        begin
            den_reg <= den_load;
            zero_reg <= (den_load == '0);
            num_reg <= apusv_pkg::QUO_BITS'({cpu_reg, 24'd0}) +
                       apusv_pkg::QUO_BITS'(den_load >> 1);
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= fits ? rem_sub : rem_shift;
            num_reg <= {num_reg[apusv_pkg::QUO_BITS-2:0], fits};
        end
        if (cmd.store)
        begin
            unique case (cmd.voice)
                2'd0: w1_reg <= wq;
                2'd1: w2_reg <= wq;
                default: w3_reg <= wq;
            endcase
        end
    end

    assign changed = changed_reg;
    assign retrigger_mask = retrig_reg;
    assign voice1_regs = v1_reg;
    assign voice2_regs = v2_reg;
    assign voice3_regs = v3_reg;
    assign global_regs = g_reg;

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> $past(status.div_done)) else $error("store before divide ends");
    a_gate_master: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) && !mode_reg |-> g_reg == {apusv_pkg::MASTER_VOLUME, 24'd0})
        else $error("master volume wrong");
    a_silence: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) && mode_reg |-> !changed_reg && retrig_reg == 3'd0)
        else $error("silence not quiet");

endmodule

// ===== src/apu_state_to_voice_registers.sv =====
// One snapshot transfer yields one register image transfer. A render runs
// three frequency words, each a 47-step restoring division on the shared
// serial divider plus a load and a store state, then the finish state builds
// the image, the output state offers it and the block returns to idle;
// silence mode skips the divisions and the finish state. Configuration
// writes are taken in any cycle, but belong between transfers so that a
// render never sees a clock change half way.
module apu_state_to_voice_registers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [21:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  pulse1_control,
    input  logic [10:0] pulse1_timer,
    input  logic [7:0]  pulse2_control,
    input  logic [10:0] pulse2_timer,
    input  logic [10:0] triangle_period,
    input  logic [7:0]  noise_control,
    input  logic [7:0]  noise_select,
    input  logic [3:0]  channel_enable,
    input  logic [3:0]  length_nonzero,
    input  logic [31:0] trigger_counts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        changed,
    output logic [2:0]  retrigger_mask,
    output logic [55:0] voice1_regs,
    output logic [55:0] voice2_regs,
    output logic [55:0] voice3_regs,
    output logic [31:0] global_regs
);

    apusv_pkg::cmd_t    cmd;
    apusv_pkg::status_t status;

    assign cfg_ready = 1'b1;

    apusv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    apusv_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .pulse1_control   (pulse1_control),
        .pulse1_timer     (pulse1_timer),
        .pulse2_control   (pulse2_control),
        .pulse2_timer     (pulse2_timer),
        .triangle_period  (triangle_period),
        .noise_control    (noise_control),
        .noise_select     (noise_select),
        .channel_enable   (channel_enable),
        .length_nonzero   (length_nonzero),
        .trigger_counts   (trigger_counts),
        .changed          (changed),
        .retrigger_mask   (retrigger_mask),
        .voice1_regs      (voice1_regs),
        .voice2_regs      (voice2_regs),
        .voice3_regs      (voice3_regs),
        .global_regs      (global_regs)
    );

endmodule

// ===== verif/apu_state_to_voice_registers_tb.sv =====
module apu_state_to_voice_registers_tb;

    typedef struct {
        logic        mode;
        logic [7:0]  p1_ctrl;
        logic [10:0] p1_timer;
        logic [7:0]  p2_ctrl;
        logic [10:0] p2_timer;
        logic [10:0] tri_timer;
        logic [7:0]  noise_ctrl;
        logic [7:0]  noise_sel;
        logic [3:0]  enable;
        logic [3:0]  len_nz;
        logic [31:0] trig;
    } snapshot_t;

    typedef struct {
        logic        changed;
        logic [2:0]  retrig;
        logic [55:0] v1;
        logic [55:0] v2;
        logic [55:0] v3;
        logic [31:0] glob;
    } image_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [21:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic mode;
    logic [7:0] pulse1_control;
    logic [10:0] pulse1_timer;
    logic [7:0] pulse2_control;
    logic [10:0] pulse2_timer;
    logic [10:0] triangle_period;
    logic [7:0] noise_control;
    logic [7:0] noise_select;
    logic [3:0] channel_enable;
    logic [3:0] length_nonzero;
    logic [31:0] trigger_counts;
    logic out_valid;
    logic out_ready;
    logic changed;
    logic [2:0] retrigger_mask;
    logic [55:0] voice1_regs;
    logic [55:0] voice2_regs;
    logic [55:0] voice3_regs;
    logic [31:0] global_regs;

    apu_state_to_voice_registers dut (.*);

    // Predictor state.
    logic [21:0] cpu_hz;
    logic [21:0] synth_hz;
    logic [7:0]  last_image [25];
    logic [7:0]  last_ctrl [3];
    logic [1:0]  last_owner;
    logic [7:0]  last_trig [4];

    snapshot_t pending_snaps[$];
    image_t    expected_images[$];
    int        mismatches;
    int        cycle_count;
    int        in_gap;
    int        out_gap;
    logic      in_fire;
    logic      out_fire;

    function automatic logic [15:0] freq_word(input logic [63:0] den);
        logic [63:0] num;
        logic [63:0] q;
        begin
            num = 64'(cpu_hz) << 24;
            if (den == 0)
                return 16'd0;
            q = (num + den / 2) / den;
            if (q > 64'hffff)
                q = 64'hffff;
            return q[15:0];
        end
    endfunction

    function automatic logic [15:0] duty_width(input logic [1:0] duty);
        begin
            case (duty)
                2'd0: return 16'h0200;
                2'd1: return 16'h0400;
                2'd2: return 16'h0800;
                default: return 16'h0c00;
            endcase
        end
    endfunction

    function automatic logic [11:0] noise_len(input logic [3:0] sel);
        logic [11:0] tbl [16];
        begin
            tbl = '{12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
                    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034,
                    12'd4068};
            return tbl[sel];
        end
    endfunction

    function automatic image_t render_image(input snapshot_t s);
        image_t r;
        logic [7:0] img [25];
        logic [7:0] ctrl;
        logic [10:0] tmr;
        logic [3:0] vol;
        logic [7:0] t;
        logic act;
        logic [15:0] w;
        logic [15:0] pw;
        logic [1:0] owner;
        logic differs;
        logic noise_on;
        logic tri_on;
        begin
            r = '{default: '0};
            if (s.mode)
            begin
                for (int i = 0; i < 25; i++)
                    last_image[i] = 8'd0;
                for (int i = 0; i < 3; i++)
                    last_ctrl[i] = 8'd0;
                last_owner = apusv_pkg::OWNER_NONE;
                return r;
            end
            for (int i = 0; i < 25; i++)
                img[i] = 8'd0;
            for (int ch = 0; ch < 2; ch++)
            begin
                ctrl = ch == 0 ? s.p1_ctrl : s.p2_ctrl;
                tmr = ch == 0 ? s.p1_timer : s.p2_timer;
                vol = ctrl[3:0];
                act = s.enable[ch] && s.len_nz[ch] && tmr >= 8 && vol != 0;
                t = s.trig[8*ch +: 8];
                w = freq_word(64'd16 * (64'(tmr) + 1) * 64'(synth_hz));
                pw = duty_width(ctrl[7:6]);
                img[ch*7] = w[7:0];
                img[ch*7+1] = w[15:8];
                img[ch*7+2] = pw[7:0];
                img[ch*7+3] = pw[15:8];
                img[ch*7+4] = apusv_pkg::CTRL_PULSE | {7'd0, act};
                img[ch*7+6] = {vol, 4'd0};
                if (act && (t != last_trig[ch] || !last_ctrl[ch][0]))
                    r.retrig[ch] = 1'b1;
                last_trig[ch] = t;
            end
            tri_on = s.enable[2] && s.len_nz[2] && s.tri_timer >= 2;
            noise_on = s.enable[3] && s.len_nz[3] && s.noise_ctrl[3:0] != 0;
            owner = noise_on ? apusv_pkg::OWNER_NOISE :
                    (tri_on ? apusv_pkg::OWNER_TRIANGLE : apusv_pkg::OWNER_NONE);
            if (owner == apusv_pkg::OWNER_NOISE)
            begin
                w = freq_word(64'd2 * 64'(noise_len(s.noise_sel[3:0])) * 64'(synth_hz));
                img[14] = w[7:0];
                img[15] = w[15:8];
                img[18] = apusv_pkg::CTRL_NOISE;
                img[20] = {s.noise_ctrl[3:0], 4'd0};
                if (s.trig[31:24] != last_trig[3] || last_owner != apusv_pkg::OWNER_NOISE
                    || !last_ctrl[2][0])
                    r.retrig[2] = 1'b1;
            end
            else if (owner == apusv_pkg::OWNER_TRIANGLE)
            begin
                w = freq_word(64'd32 * (64'(s.tri_timer) + 1) * 64'(synth_hz));
                img[14] = w[7:0];
                img[15] = w[15:8];
                img[18] = apusv_pkg::CTRL_TRIANGLE;
                img[20] = apusv_pkg::VOLUME_FULL;
                if (s.trig[23:16] != last_trig[2] || last_owner != apusv_pkg::OWNER_TRIANGLE
                    || !last_ctrl[2][0])
                    r.retrig[2] = 1'b1;
            end
            else
                img[18] = apusv_pkg::CTRL_OFF;
            last_trig[2] = s.trig[23:16];
            last_trig[3] = s.trig[31:24];
            img[24] = apusv_pkg::MASTER_VOLUME;
            differs = 1'b0;
            for (int i = 0; i < 25; i++)
                if (img[i] != last_image[i])
                    differs = 1'b1;
            r.changed = r.retrig != 0 || differs;
            for (int i = 0; i < 25; i++)
                last_image[i] = img[i];
            last_ctrl[0] = img[4];
            last_ctrl[1] = img[11];
            last_ctrl[2] = img[18];
            last_owner = owner;
            for (int i = 0; i < 7; i++)
            begin
                r.v1[8*i +: 8] = img[i];
                r.v2[8*i +: 8] = img[7+i];
                r.v3[8*i +: 8] = img[14+i];
            end
            for (int i = 0; i < 4; i++)
                r.glob[8*i +: 8] = img[21+i];
            return r;
        end
    endfunction

    // Random snapshot, mostly with audible channels so that the voice 3 owner
    // and retrigger logic get exercised; timers are biased towards the low
    // thresholds now and then.
    function automatic snapshot_t random_snapshot();
        snapshot_t s;
        begin
            s.mode = $urandom_range(0, 19) == 0;
            s.p1_ctrl = 8'($urandom);
            s.p2_ctrl = 8'($urandom);
            s.p1_timer = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 12)) :
                         11'($urandom);
            s.p2_timer = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 12)) :
                         11'($urandom);
            s.tri_timer = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 4)) :
                          11'($urandom);
            s.noise_ctrl = $urandom_range(0, 3) == 0 ? {4'($urandom), 4'd0} : 8'($urandom);
            s.noise_sel = 8'($urandom);
            s.enable = $urandom_range(0, 2) == 0 ? 4'($urandom) : 4'hf;
            s.len_nz = $urandom_range(0, 2) == 0 ? 4'($urandom) : 4'hf;
            s.trig = $urandom_range(0, 1) ? $urandom : {6'd0, 2'($urandom), 6'd0,
                     2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)};
            return s;
        end
    endfunction

    function automatic snapshot_t make_snapshot(input logic m, input logic [7:0] c1,
        input logic [10:0] t1, input logic [7:0] c2, input logic [10:0] t2,
        input logic [10:0] tt, input logic [7:0] nc, input logic [7:0] ns,
        input logic [3:0] en, input logic [3:0] ln, input logic [31:0] tg);
        snapshot_t s;
        begin
            s = '{m, c1, t1, c2, t2, tt, nc, ns, en, ln, tg};
            return s;
        end
    endfunction

    task automatic write_clock(input logic [0:0] idx, input logic [21:0] val);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx == apusv_pkg::CFG_CPU_CLOCK)
                cpu_hz = val;
            else
                synth_hz = val;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        begin
            while (pending_snaps.size() != 0 || expected_images.size() != 0)
                @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Driver: one snapshot at a time from the queue, after a random gap.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (in_fire)
        begin
            // The transfer happened at the last rising edge.
            in_valid <= 1'b0;
            in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        end
        else if (!in_valid && pending_snaps.size() != 0)
        begin
            if (in_gap != 0)
                in_gap <= in_gap - 1;
            else
            begin
                mode <= pending_snaps[0].mode;
                pulse1_control <= pending_snaps[0].p1_ctrl;
                pulse1_timer <= pending_snaps[0].p1_timer;
                pulse2_control <= pending_snaps[0].p2_ctrl;
                pulse2_timer <= pending_snaps[0].p2_timer;
                triangle_period <= pending_snaps[0].tri_timer;
                noise_control <= pending_snaps[0].noise_ctrl;
                noise_select <= pending_snaps[0].noise_sel;
                channel_enable <= pending_snaps[0].enable;
                length_nonzero <= pending_snaps[0].len_nz;
                trigger_counts <= pending_snaps[0].trig;
                in_valid <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
            expected_images.push_back(render_image(pending_snaps.pop_front()));
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else if (out_fire)
        begin
            out_ready <= 1'b0;
            out_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        end
        else if (!out_ready)
        begin
            if (out_gap != 0)
                out_gap <= out_gap - 1;
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        image_t e;
        out_fire = rst_n && out_valid && out_ready;
        if (out_fire)
        begin
            if (expected_images.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected register image transfer");
            end
            else
            begin
                e = expected_images.pop_front();
                if (changed !== e.changed || retrigger_mask !== e.retrig
                    || voice1_regs !== e.v1 || voice2_regs !== e.v2
                    || voice3_regs !== e.v3 || global_regs !== e.glob)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Image mismatch: expected %b %h %h %h %h %h, got %b %h %h %h %h %h",
                                 e.changed, e.retrig, e.v1, e.v2, e.v3, e.glob,
                                 changed, retrigger_mask, voice1_regs, voice2_regs,
                                 voice3_regs, global_regs);
                end
            end
        end
    end

    initial
    begin
        logic [21:0] cpu_set [4];
        logic [21:0] synth_set [4];
        mismatches = 0;
        cpu_hz = apusv_pkg::CPU_CLOCK_RESET;
        synth_hz = apusv_pkg::SYNTH_CLOCK_RESET;
        for (int i = 0; i < 25; i++)
            last_image[i] = 8'd0;
        for (int i = 0; i < 3; i++)
            last_ctrl[i] = 8'd0;
        for (int i = 0; i < 4; i++)
            last_trig[i] = 8'd0;
        last_owner = apusv_pkg::OWNER_NONE;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = apusv_pkg::CFG_CPU_CLOCK;
        cfg_data = '0;
        mode = 1'b0;
        pulse1_control = '0;
        pulse1_timer = '0;
        pulse2_control = '0;
        pulse2_timer = '0;
        triangle_period = '0;
        noise_control = '0;
        noise_select = '0;
        channel_enable = '0;
        length_nonzero = '0;
        trigger_counts = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: thresholds, owner handover, silence, field extremes.
        pending_snaps.push_back(make_snapshot(0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        pending_snaps.push_back(make_snapshot(0, 8'h3f, 7, 8'h7f, 8, 1, 8'h00, 8'h0f,
                                              4'hf, 4'hf, 32'h0));
        pending_snaps.push_back(make_snapshot(0, 8'hbf, 8, 8'hff, 2047, 2, 8'h00, 0,
                                              4'hf, 4'hf, 32'h0));
        pending_snaps.push_back(make_snapshot(0, 8'hbf, 8, 8'hff, 2047, 2, 8'h00, 0,
                                              4'hf, 4'hf, 32'h0));
        pending_snaps.push_back(make_snapshot(0, 8'hc1, 2047, 8'h81, 100, 2047, 8'h0f,
                                              8'hf0, 4'hf, 4'hf, 32'hffffffff));
        pending_snaps.push_back(make_snapshot(0, 8'hc1, 2047, 8'h81, 100, 2047, 8'h0f,
                                              8'hff, 4'hf, 4'hf, 32'hffffffff));
        pending_snaps.push_back(make_snapshot(0, 8'h41, 500, 8'h01, 500, 500, 8'hf0,
                                              8'h0e, 4'h7, 4'hf, 32'h01010101));
        pending_snaps.push_back(make_snapshot(1, 8'hff, 2047, 8'hff, 2047, 2047, 8'hff,
                                              8'hff, 4'hf, 4'hf, 32'hffffffff));
        pending_snaps.push_back(make_snapshot(0, 8'h41, 500, 8'h01, 500, 500, 8'h05,
                                              8'h00, 4'hb, 4'hd, 32'h01010101));
        pending_snaps.push_back(make_snapshot(0, 8'h41, 500, 8'h01, 500, 500, 8'h05,
                                              8'h00, 4'hf, 4'hf, 32'h80402010));
        drain();

        cpu_set = '{22'd1, 22'h3fffff, 22'd1789773, 22'($urandom)};
        synth_set = '{22'h3fffff, 22'd1, 22'd985248, 22'($urandom_range(1, 4194303))};
        for (int phase = 0; phase < 4; phase++)
        begin
            write_clock(apusv_pkg::CFG_CPU_CLOCK, cpu_set[phase]);
            write_clock(apusv_pkg::CFG_SYNTH_CLOCK, synth_set[phase]);
            for (int i = 0; i < 175; i++)
            begin
                pending_snaps.push_back(random_snapshot());
                if (i == 90)
                begin
                    // Hold off until every outstanding image has been returned.
                    while (pending_snaps.size() != 0 || expected_images.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
